// ===== hdl/rksd_pkg.sv =====
// Shared constants and widths for the running k-th smallest distance block.
package rksd_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int COORD_BITS = 21;

  localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int K_W    = 7;
  localparam int SUM_W  = 2 * COORD_BITS;
  localparam int KTH_W  = 42;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// ===== hdl/rksd_in_if.sv =====
// Input channel: command and point coordinates with valid/ready.
interface rksd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    command;
  logic signed [rksd_pkg::COORD_BITS-1:0]  x_coord;
  logic signed [rksd_pkg::COORD_BITS-1:0]  y_coord;

  modport source (output valid, command, x_coord, y_coord, input ready);
  modport sink   (input valid, command, x_coord, y_coord, output ready);
endinterface

// ===== hdl/rksd_out_if.sv =====
// Output channel: k-th smallest distance and underfill flag with valid/ready.
interface rksd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rksd_pkg::KTH_W-1:0]   kth_distance;
  logic                         underfilled;

  modport source (output valid, kth_distance, underfilled, input ready);
  modport sink   (input valid, kth_distance, underfilled, output ready);
endinterface

// ===== hdl/running_kth_smallest_distance.sv =====
// Add: squares in ST_MULX and ST_MULY, sum in ST_ADD, check in ST_CHK; a rejected value
//   ends there, else the one-port sorted store shifts entries up through ST_SRD and ST_SWR.
// Query: read in ST_QRD, output in ST_QOUT once free; one transaction in work at a time.
// Squares come from one shared multiplier used twice per add.
// Reset clears the control state, the fill count and sets k to 1; the store is
//   not cleared, entries above the fill count are never used.
module running_kth_smallest_distance (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rksd_pkg::K_W-1:0]   cfg_wdata_i,
  rksd_in_if.sink                    in_ch,
  rksd_out_if.source                 out_ch
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULX = 4'd1;
  localparam logic [3:0] ST_MULY = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_SRD  = 4'd5;
  localparam logic [3:0] ST_SWR  = 4'd6;
  localparam logic [3:0] ST_QRD  = 4'd7;
  localparam logic [3:0] ST_QOUT = 4'd8;

  logic [3:0]                          state_q, state_d;
  logic [rksd_pkg::K_W-1:0]            k_q;
  logic [rksd_pkg::CNT_W-1:0]          held_q, held_d;
  logic [rksd_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [rksd_pkg::ADDR_W-1:0]         qaddr_q, qaddr_d;
  logic                                qzero_q, qzero_d;
  logic                                qunder_q, qunder_d;
  logic [rksd_pkg::COORD_BITS-1:0]     mx_q, mx_d, my_q, my_d;
  logic [rksd_pkg::SUM_W-1:0]          prod_q, prod_d;
  logic [rksd_pkg::SUM_W-1:0]          sq_q, dist_q, dist_d;
  logic                                out_valid_q, out_valid_d;
  logic [rksd_pkg::KTH_W-1:0]          kth_q, kth_d;
  logic                                under_q, under_d;

  logic [rksd_pkg::CNT_W-1:0]          k_eff;
  logic [rksd_pkg::COORD_BITS-1:0]     mul_a;
  logic [rksd_pkg::SUM_W-1:0]          mem [rksd_pkg::MAX_KEPT];
  logic [rksd_pkg::SUM_W-1:0]          rd_data_q;
  logic [rksd_pkg::ADDR_W-1:0]         rd_addr;
  logic                                mem_we;
  logic [rksd_pkg::SUM_W-1:0]          mem_wdata;
  logic [rksd_pkg::KTH_W+rksd_pkg::SUM_W-1:0] kth_ext;

  function automatic logic [rksd_pkg::COORD_BITS-1:0] mag(
    input logic [rksd_pkg::COORD_BITS-1:0] v
  );
    logic [rksd_pkg::COORD_BITS-1:0] r;
    r = v[rksd_pkg::COORD_BITS-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  // Clamp the rank to 1..MAX_KEPT.
  always_comb begin
    if (k_q == '0) begin
      k_eff = rksd_pkg::CNT_W'(1);
    end else if (32'(k_q) > 32'(rksd_pkg::MAX_KEPT)) begin
      k_eff = rksd_pkg::CNT_W'(rksd_pkg::MAX_KEPT);
    end else begin
      k_eff = rksd_pkg::CNT_W'(k_q);
    end
  end

  // Shared squarer.
  assign mul_a  = (state_q == ST_MULY) ? my_q : mx_q;
  assign prod_d = rksd_pkg::SUM_W'(mul_a) * rksd_pkg::SUM_W'(mul_a);

  always_comb begin
    case (state_q) inside
      ST_ADD:           rd_addr = rksd_pkg::ADDR_W'(k_eff - 1'b1);
      ST_SRD:           rd_addr = idx_q - 1'b1;
      ST_QRD, ST_QOUT:  rd_addr = qaddr_q;
      default:          rd_addr = '0;
    endcase
  end

  assign kth_ext = {{rksd_pkg::KTH_W{1'b0}}, rd_data_q};

  assign in_ch.ready         = (state_q == ST_IDLE);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.kth_distance = kth_q;
  assign out_ch.underfilled  = under_q;

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    idx_d       = idx_q;
    qaddr_d     = qaddr_q;
    qzero_d     = qzero_q;
    qunder_d    = qunder_q;
    mx_d        = mx_q;
    my_d        = my_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q;
    kth_d       = kth_q;
    under_d     = under_q;
    mem_we      = 1'b0;
    mem_wdata   = dist_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == rksd_pkg::CMD_ADD) begin
            mx_d    = mag(in_ch.x_coord);
            my_d    = mag(in_ch.y_coord);
            state_d = ST_MULX;
          end else begin
            qzero_d = (held_q == '0);
            if (held_q >= k_eff) begin
              qaddr_d  = rksd_pkg::ADDR_W'(k_eff - 1'b1);
              qunder_d = 1'b0;
            end else begin
              qaddr_d  = rksd_pkg::ADDR_W'(held_q - 1'b1);
              qunder_d = 1'b1;
            end
            state_d = ST_QRD;
          end
        end
      end
      ST_MULX: state_d = ST_MULY;
      ST_MULY: state_d = ST_ADD;
      ST_ADD: begin
        dist_d  = sq_q + prod_q;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (held_q < k_eff) begin
          idx_d   = rksd_pkg::ADDR_W'(held_q);
          held_d  = held_q + 1'b1;
          state_d = ST_SRD;
        end else if (dist_q <= rd_data_q) begin
          // Full store: the old k-th value drops out.
          idx_d   = rksd_pkg::ADDR_W'(k_eff - 1'b1);
          held_d  = k_eff;
          state_d = ST_SRD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SRD: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SWR;
        end
      end
      ST_SWR: begin
        mem_we = 1'b1;
        if (rd_data_q > dist_q) begin
          // Move the larger neighbor up one place and keep walking down.
          mem_wdata = rd_data_q;
          idx_d     = idx_q - 1'b1;
          state_d   = ST_SRD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_QRD: state_d = ST_QOUT;
      ST_QOUT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          kth_d       = qzero_q ? '0 : kth_ext[rksd_pkg::KTH_W-1:0];
          under_d     = qunder_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= rksd_pkg::K_W'(1);
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    qaddr_q  <= qaddr_d;
    qzero_q  <= qzero_d;
    qunder_q <= qunder_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    prod_q   <= prod_d;
    sq_q     <= prod_q;
    dist_q   <= dist_d;
    kth_q    <= kth_d;
    under_q  <= under_d;
  end

  // Sorted store: at most one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule
